// ----- rtl/crs_pkg.sv -----
// ----------------------------------------------------------------------------
// crs_pkg
// Shared widths, codes, constants and types of the coil ratio steering unit.
// ----------------------------------------------------------------------------
package crs_pkg;

   // coil sum accumulation
   localparam int SUM_BITS  = 24;
   localparam int AVG_SHIFT = 2;
   localparam int AVG_W     = SUM_BITS - AVG_SHIFT;
   localparam int TOT_W     = AVG_W + 1;

   // channel field widths
   localparam int OP_W      = 2;
   localparam int SAMPLE_W  = 15;
   localparam int GYRO_W    = 16;
   localparam int PHASE_W   = 8;
   localparam int OUT_W     = 14;
   localparam int REGIME_W  = 2;
   localparam int DIR_W     = OUT_W;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int GAIN_P_W   = 16;
   localparam int GAIN_D_W   = 24;
   localparam int COEF_W     = 16;
   localparam int PERIOD_W   = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADC_OFFSET  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_OFFSET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAD_COEF   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LIN_COEF    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_LEN  = 3'd7;

   localparam logic [GAIN_P_W-1:0] GAIN_P_RESET = 16'd256;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd5;

   // operations
   localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
   localparam logic [OP_W-1:0] OP_CONTROL = 2'd1;
   localparam logic [OP_W-1:0] OP_OUTPUT  = 2'd2;

   // gain schedules
   localparam logic [REGIME_W-1:0] REGIME_STRAIGHT = 2'd0;
   localparam logic [REGIME_W-1:0] REGIME_NORMAL   = 2'd1;
   localparam logic [REGIME_W-1:0] REGIME_SHARP    = 2'd2;

   // control law constants
   localparam int LIMIT         = 6000;
   localparam int DIR_SCALE     = 5632;
   localparam int DIR_Q_W       = 13;
   localparam int DIR_SCALE_W   = 13;
   localparam int COUNT_W       = 8;
   localparam int STRAIGHT_BAND = 256;
   localparam int SHARP_BAND    = 2560;
   localparam int STRAIGHT_RUN  = 20;
   localparam int STRAIGHT_GAIN = 179;
   localparam int SHARP_BIAS    = 600;
   localparam int NORMAL_SHIFT  = 16;
   localparam int FRAC_SHIFT    = 24;
   localparam int LIN_SHIFT     = 8;
   localparam int G_W           = GYRO_W + 1;

   // shared multiplier
   localparam int MUL_A_W = 43;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 52;

   // iterative divider
   localparam int NUM_W = AVG_W + DIR_SCALE_W;
   localparam int DEN_W = TOT_W;
   localparam int QUO_W = 22;
   localparam int TOP_W = $clog2(QUO_W);
   localparam int DSH_W = DEN_W + QUO_W - 1;

   localparam logic [TOP_W-1:0] DIR_TOP    = TOP_W'(DIR_Q_W - 1);
   localparam logic [TOP_W-1:0] INTERP_TOP = TOP_W'(QUO_W - 1);

   localparam logic signed [MUL_B_W-1:0] DIR_SCALE_B     = MUL_B_W'(DIR_SCALE);
   localparam logic signed [MUL_B_W-1:0] STRAIGHT_GAIN_B = MUL_B_W'(STRAIGHT_GAIN);
   localparam logic [COUNT_W-1:0]        STRAIGHT_RUN_C  = COUNT_W'(STRAIGHT_RUN);
   localparam logic [DIR_Q_W-1:0]        STRAIGHT_BAND_C = DIR_Q_W'(STRAIGHT_BAND);
   localparam logic [DIR_W-1:0]          SHARP_BAND_C    = DIR_W'(SHARP_BAND);
   localparam logic signed [ACC_W-1:0]   SHARP_BIAS_ACC  =
      ACC_W'(64'(SHARP_BIAS) << FRAC_SHIFT);
   localparam logic signed [ACC_W-1:0]   ACC_LIMIT_HI    = ACC_W'(LIMIT);
   localparam logic signed [ACC_W-1:0]   ACC_LIMIT_LO    = ACC_W'(-LIMIT);
   localparam logic signed [OUT_W-1:0]   OUT_LIMIT_HI    = OUT_W'(LIMIT);
   localparam logic signed [OUT_W-1:0]   OUT_LIMIT_LO    = OUT_W'(-LIMIT);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CTL_MUL,
      ST_CTL_DIVST,
      ST_CTL_DIV,
      ST_PD_M0,
      ST_PD_M1,
      ST_PD_M2,
      ST_PD_M3,
      ST_PD_M4,
      ST_SH_1,
      ST_SH_2,
      ST_SH_3,
      ST_SH_4,
      ST_PD_END,
      ST_OUT_MUL,
      ST_OUT_DIVST,
      ST_OUT_DIV,
      ST_FINISH
   } crs_state_type;

   typedef struct packed {
      logic             start;
      logic [TOP_W-1:0] top;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } crs_div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } crs_div_rsp_type;

endpackage

// ----- rtl/crs_req_if.sv -----
// ----------------------------------------------------------------------------
// crs_req_if
// Input item channel: valid/ready handshake with operation and readings.
// ----------------------------------------------------------------------------
interface crs_req_if;
   logic                                valid;
   logic                                ready;
   logic [crs_pkg::OP_W-1:0]            operation;
   logic [crs_pkg::SAMPLE_W-1:0]        left_sample;
   logic [crs_pkg::SAMPLE_W-1:0]        right_sample;
   logic signed [crs_pkg::GYRO_W-1:0]   gyro;
   logic [crs_pkg::PHASE_W-1:0]         phase;

   modport source (
      output valid, operation, left_sample, right_sample, gyro, phase,
      input  ready
   );

   modport sink (
      input  valid, operation, left_sample, right_sample, gyro, phase,
      output ready
   );
endinterface

// ----- rtl/crs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// crs_rsp_if
// Result item channel: valid/ready handshake with drive, target and status.
// ----------------------------------------------------------------------------
interface crs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [crs_pkg::OUT_W-1:0]   drive;
   logic signed [crs_pkg::OUT_W-1:0]   target;
   logic signed [crs_pkg::OUT_W-1:0]   direction;
   logic [crs_pkg::REGIME_W-1:0]       regime;

   modport source (
      output valid, drive, target, direction, regime,
      input  ready
   );

   modport sink (
      input  valid, drive, target, direction, regime,
      output ready
   );
endinterface

// ----- rtl/crs_mult.sv -----
// ----------------------------------------------------------------------------
// crs_mult
// Shared signed multiplier with a registered product, one product per cycle.
// ----------------------------------------------------------------------------
module crs_mult (
   input  logic                                clock,
   input  logic signed [crs_pkg::MUL_A_W-1:0]  mul_a,
   input  logic signed [crs_pkg::MUL_B_W-1:0]  mul_b,
   output logic signed [crs_pkg::MUL_P_W-1:0]  mul_p
);

   logic signed [crs_pkg::MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign mul_p = prod_ff;

endmodule

// ----- rtl/crs_divider.sv -----
// ----------------------------------------------------------------------------
// crs_divider
// Radix-2 restoring divider, one quotient bit per cycle from bit top down.
// ----------------------------------------------------------------------------
module crs_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  crs_pkg::crs_div_req_type   div_req,
   output crs_pkg::crs_div_rsp_type   div_rsp
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [crs_pkg::TOP_W-1:0]   cnt_ff, cnt_in;
   logic [crs_pkg::NUM_W-1:0]   rem_ff, rem_in;
   logic [crs_pkg::DSH_W-1:0]   dsh_ff, dsh_in;
   logic [crs_pkg::QUO_W-1:0]   quo_ff, quo_in;
   logic [crs_pkg::DSH_W-1:0]   rem_ext;
   logic [crs_pkg::DSH_W-1:0]   rem_diff;
   logic                        fits;

   always_comb begin
      rem_ext  = {{(crs_pkg::DSH_W-crs_pkg::NUM_W){1'b0}}, rem_ff};
      rem_diff = rem_ext - dsh_ff;
      fits     = (rem_ext >= dsh_ff);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.top;
         rem_in  = div_req.numer;
         dsh_in  = {{(crs_pkg::DSH_W-crs_pkg::DEN_W){1'b0}}, div_req.denom} << div_req.top;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_diff[crs_pkg::NUM_W-1:0];
         end
         quo_in = {quo_ff[crs_pkg::QUO_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- rtl/coil_ratio_steering_pd_unit.sv -----
// ----------------------------------------------------------------------------
// coil_ratio_steering_pd_unit
// Coil ratio steering controller with gain-scheduled PD law and interpolation.
// ----------------------------------------------------------------------------
// Takes one item at a time and returns one result per item carrying drive,
// target, direction and regime. A coil sample or an unused operation goes
// straight to the result stage, as does a disabled control item or an output
// step with a zero period. An enabled control item and an output step take
// longer: their sequences are set by the restoring divider, which yields one
// quotient bit per cycle (13 bits for the direction ratio, 22 bits for the
// interpolation), and by the single registered multiplier that the PD terms
// share in turn. A finished result sits in the output register, and the next
// item is taken while it waits; only a second finished result waits for the
// first to transfer.
module coil_ratio_steering_pd_unit (
   input  logic                               clock,
   input  logic                               reset,
   crs_req_if.sink                            req_ch,
   crs_rsp_if.source                          rsp_ch,
   input  logic                               csr_wr_en,
   input  logic [crs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [crs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // configuration
   logic                                 enable_ff;
   logic [crs_pkg::SAMPLE_W-1:0]         adc_offset_ff;
   logic signed [crs_pkg::GYRO_W-1:0]    gyro_offset_ff;
   logic [crs_pkg::GAIN_P_W-1:0]         gain_p_ff;
   logic [crs_pkg::GAIN_D_W-1:0]         gain_d_ff;
   logic [crs_pkg::COEF_W-1:0]           quad_coef_ff;
   logic signed [crs_pkg::COEF_W-1:0]    lin_coef_ff;
   logic [crs_pkg::PERIOD_W-1:0]         period_len_ff;

   // controller state
   crs_pkg::crs_state_type               state_ff, state_in;
   logic [crs_pkg::SUM_BITS-1:0]         left_sum_ff, left_sum_in;
   logic [crs_pkg::SUM_BITS-1:0]         right_sum_ff, right_sum_in;
   logic [crs_pkg::COUNT_W-1:0]          straight_count_ff, straight_count_in;
   logic signed [crs_pkg::OUT_W-1:0]     target_old_ff, target_old_in;
   logic signed [crs_pkg::OUT_W-1:0]     target_new_ff, target_new_in;
   logic signed [crs_pkg::OUT_W-1:0]     drive_value_ff, drive_value_in;
   logic signed [crs_pkg::DIR_W-1:0]     direction_value_ff, direction_value_in;
   logic [crs_pkg::REGIME_W-1:0]         regime_value_ff, regime_value_in;

   // working registers
   logic signed [crs_pkg::ACC_W-1:0]     acc_ff, acc_in;
   logic signed [crs_pkg::G_W-1:0]       g_ff, g_in;
   logic [crs_pkg::TOT_W-1:0]            tot_ff, tot_in;
   logic [crs_pkg::AVG_W-1:0]            adiff_ff, adiff_in;
   logic                                 neg_ff, neg_in;
   logic [crs_pkg::PHASE_W-1:0]          phase_ff, phase_in;

   // result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [crs_pkg::OUT_W-1:0]     rsp_drive_ff, rsp_drive_in;
   logic signed [crs_pkg::OUT_W-1:0]     rsp_target_ff, rsp_target_in;
   logic signed [crs_pkg::OUT_W-1:0]     rsp_direction_ff, rsp_direction_in;
   logic [crs_pkg::REGIME_W-1:0]         rsp_regime_ff, rsp_regime_in;

   // shared units
   logic signed [crs_pkg::MUL_A_W-1:0]   mul_a;
   logic signed [crs_pkg::MUL_B_W-1:0]   mul_b;
   logic signed [crs_pkg::MUL_P_W-1:0]   mul_p;
   crs_pkg::crs_div_req_type             div_req;
   crs_pkg::crs_div_rsp_type             div_rsp;

   // helpers
   logic [crs_pkg::SAMPLE_W-1:0]         left_sub, right_sub;
   logic [crs_pkg::SUM_BITS:0]           left_add, right_add;
   logic [crs_pkg::SUM_BITS-1:0]         left_sat, right_sat;
   logic [crs_pkg::AVG_W-1:0]            left_avg, right_avg;
   logic [crs_pkg::TOT_W-1:0]            avg_tot;
   logic signed [crs_pkg::G_W-1:0]       g_new;
   logic [crs_pkg::DIR_Q_W-1:0]          dir_mag;
   logic signed [crs_pkg::DIR_W-1:0]     dir_new;
   logic [crs_pkg::DIR_W-1:0]            dir_abs;
   logic [crs_pkg::REGIME_W-1:0]         regime_sel;
   logic signed [crs_pkg::ACC_W-1:0]     acc_sh;
   logic signed [crs_pkg::ACC_W-1:0]     sharp_lin_sum;
   logic signed [crs_pkg::OUT_W:0]       tdiff;
   logic [crs_pkg::MUL_P_W-1:0]          prod_abs;
   logic signed [crs_pkg::QUO_W:0]       interp_q;
   logic signed [crs_pkg::ACC_W-1:0]     interp_sum;

   function automatic logic signed [crs_pkg::OUT_W-1:0] clamp_out(
      input logic signed [crs_pkg::ACC_W-1:0] v
   );
      logic signed [crs_pkg::OUT_W-1:0] r;
      if (v > crs_pkg::ACC_LIMIT_HI) begin
         r = crs_pkg::OUT_LIMIT_HI;
      end else if (v < crs_pkg::ACC_LIMIT_LO) begin
         r = crs_pkg::OUT_LIMIT_LO;
      end else begin
         r = v[crs_pkg::OUT_W-1:0];
      end
      return r;
   endfunction

   crs_mult u_mult (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   crs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         adc_offset_ff  <= '0;
         gyro_offset_ff <= '0;
         gain_p_ff      <= crs_pkg::GAIN_P_RESET;
         gain_d_ff      <= '0;
         quad_coef_ff   <= '0;
         lin_coef_ff    <= '0;
         period_len_ff  <= crs_pkg::PERIOD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            crs_pkg::CSR_ENABLE: begin
               enable_ff <= csr_wdata[0];
            end
            crs_pkg::CSR_ADC_OFFSET: begin
               adc_offset_ff <= csr_wdata[crs_pkg::SAMPLE_W-1:0];
            end
            crs_pkg::CSR_GYRO_OFFSET: begin
               gyro_offset_ff <= csr_wdata[crs_pkg::GYRO_W-1:0];
            end
            crs_pkg::CSR_GAIN_P: begin
               gain_p_ff <= csr_wdata[crs_pkg::GAIN_P_W-1:0];
            end
            crs_pkg::CSR_GAIN_D: begin
               gain_d_ff <= csr_wdata[crs_pkg::GAIN_D_W-1:0];
            end
            crs_pkg::CSR_QUAD_COEF: begin
               quad_coef_ff <= csr_wdata[crs_pkg::COEF_W-1:0];
            end
            crs_pkg::CSR_LIN_COEF: begin
               lin_coef_ff <= csr_wdata[crs_pkg::COEF_W-1:0];
            end
            crs_pkg::CSR_PERIOD_LEN: begin
               period_len_ff <= csr_wdata[crs_pkg::PERIOD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // sample path: offset removal floored at zero, saturating sums
   assign left_sub  = (req_ch.left_sample > adc_offset_ff) ?
                      req_ch.left_sample - adc_offset_ff : '0;
   assign right_sub = (req_ch.right_sample > adc_offset_ff) ?
                      req_ch.right_sample - adc_offset_ff : '0;
   assign left_add  = {1'b0, left_sum_ff} +
                      {{(crs_pkg::SUM_BITS+1-crs_pkg::SAMPLE_W){1'b0}}, left_sub};
   assign right_add = {1'b0, right_sum_ff} +
                      {{(crs_pkg::SUM_BITS+1-crs_pkg::SAMPLE_W){1'b0}}, right_sub};
   assign left_sat  = left_add[crs_pkg::SUM_BITS] ? '1 : left_add[crs_pkg::SUM_BITS-1:0];
   assign right_sat = right_add[crs_pkg::SUM_BITS] ? '1 : right_add[crs_pkg::SUM_BITS-1:0];

   // averages and ratio operands
   assign left_avg  = left_sum_ff[crs_pkg::SUM_BITS-1:crs_pkg::AVG_SHIFT];
   assign right_avg = right_sum_ff[crs_pkg::SUM_BITS-1:crs_pkg::AVG_SHIFT];
   assign avg_tot   = {1'b0, left_avg} + {1'b0, right_avg};
   assign g_new     = {req_ch.gyro[crs_pkg::GYRO_W-1], req_ch.gyro} -
                      {gyro_offset_ff[crs_pkg::GYRO_W-1], gyro_offset_ff};

   // direction from quotient, zero when the sum is zero
   assign dir_mag = (tot_ff == '0) ? '0 : div_rsp.quotient[crs_pkg::DIR_Q_W-1:0];
   assign dir_new = neg_ff ? -$signed({1'b0, dir_mag}) : $signed({1'b0, dir_mag});
   assign dir_abs = direction_value_ff[crs_pkg::DIR_W-1] ?
                    -direction_value_ff : direction_value_ff;

   always_comb begin
      if (straight_count_ff > crs_pkg::STRAIGHT_RUN_C) begin
         regime_sel = crs_pkg::REGIME_STRAIGHT;
      end else if (dir_abs < crs_pkg::SHARP_BAND_C) begin
         regime_sel = crs_pkg::REGIME_NORMAL;
      end else begin
         regime_sel = crs_pkg::REGIME_SHARP;
      end
   end

   assign acc_sh = (regime_value_ff == crs_pkg::REGIME_NORMAL) ?
                   (acc_ff >>> crs_pkg::NORMAL_SHIFT) : (acc_ff >>> crs_pkg::FRAC_SHIFT);
   assign sharp_lin_sum = acc_ff +
      $signed({mul_p[crs_pkg::ACC_W-crs_pkg::LIN_SHIFT-1:0], {crs_pkg::LIN_SHIFT{1'b0}}});

   // interpolation terms
   assign tdiff      = {target_new_ff[crs_pkg::OUT_W-1], target_new_ff} -
                       {target_old_ff[crs_pkg::OUT_W-1], target_old_ff};
   assign prod_abs   = mul_p[crs_pkg::MUL_P_W-1] ? -mul_p : mul_p;
   assign interp_q   = neg_ff ? -$signed({1'b0, div_rsp.quotient}) :
                                 $signed({1'b0, div_rsp.quotient});
   assign interp_sum = {{(crs_pkg::ACC_W-crs_pkg::QUO_W-1){interp_q[crs_pkg::QUO_W]}}, interp_q} +
                       {{(crs_pkg::ACC_W-crs_pkg::OUT_W){target_old_ff[crs_pkg::OUT_W-1]}},
                        target_old_ff};

   assign req_ch.ready = (state_ff == crs_pkg::ST_IDLE);

   // sequencer
   always_comb begin
      state_in           = state_ff;
      left_sum_in        = left_sum_ff;
      right_sum_in       = right_sum_ff;
      straight_count_in  = straight_count_ff;
      target_old_in      = target_old_ff;
      target_new_in      = target_new_ff;
      drive_value_in     = drive_value_ff;
      direction_value_in = direction_value_ff;
      regime_value_in    = regime_value_ff;
      acc_in             = acc_ff;
      g_in               = g_ff;
      tot_in             = tot_ff;
      adiff_in           = adiff_ff;
      neg_in             = neg_ff;
      phase_in           = phase_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ch.ready;
      rsp_drive_in       = rsp_drive_ff;
      rsp_target_in      = rsp_target_ff;
      rsp_direction_in   = rsp_direction_ff;
      rsp_regime_in      = rsp_regime_ff;
      mul_a              = '0;
      mul_b              = '0;
      div_req            = '0;

      case (state_ff)
         crs_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = crs_pkg::ST_FINISH;
               case (req_ch.operation)
                  crs_pkg::OP_SAMPLE: begin
                     left_sum_in  = left_sat;
                     right_sum_in = right_sat;
                  end
                  crs_pkg::OP_CONTROL: begin
                     if (!enable_ff) begin
                        target_old_in  = '0;
                        target_new_in  = '0;
                        drive_value_in = '0;
                     end else begin
                        tot_in       = avg_tot;
                        neg_in       = (left_avg < right_avg);
                        adiff_in     = (left_avg < right_avg) ? right_avg - left_avg :
                                                                left_avg - right_avg;
                        g_in         = g_new;
                        left_sum_in  = '0;
                        right_sum_in = '0;
                        state_in     = crs_pkg::ST_CTL_MUL;
                     end
                  end
                  crs_pkg::OP_OUTPUT: begin
                     if (period_len_ff == '0) begin
                        drive_value_in = target_new_ff;
                     end else begin
                        phase_in = req_ch.phase;
                        state_in = crs_pkg::ST_OUT_MUL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         crs_pkg::ST_CTL_MUL: begin
            mul_a    = {{(crs_pkg::MUL_A_W-crs_pkg::AVG_W){1'b0}}, adiff_ff};
            mul_b    = crs_pkg::DIR_SCALE_B;
            state_in = crs_pkg::ST_CTL_DIVST;
         end
         crs_pkg::ST_CTL_DIVST: begin
            div_req.start = 1'b1;
            div_req.top   = crs_pkg::DIR_TOP;
            div_req.numer = mul_p[crs_pkg::NUM_W-1:0];
            div_req.denom = tot_ff;
            state_in      = crs_pkg::ST_CTL_DIV;
         end
         crs_pkg::ST_CTL_DIV: begin
            if (div_rsp.done) begin
               direction_value_in = dir_new;
               target_old_in      = target_new_ff;
               if (dir_mag < crs_pkg::STRAIGHT_BAND_C) begin
                  if (straight_count_ff != '1) begin
                     straight_count_in = straight_count_ff + 1'b1;
                  end
               end else begin
                  straight_count_in = '0;
               end
               state_in = crs_pkg::ST_PD_M0;
            end
         end
         crs_pkg::ST_PD_M0: begin
            regime_value_in = regime_sel;
            mul_b = {{(crs_pkg::MUL_B_W-crs_pkg::DIR_W){direction_value_ff[crs_pkg::DIR_W-1]}},
                     direction_value_ff};
            if (regime_sel == crs_pkg::REGIME_SHARP) begin
               mul_a = {{(crs_pkg::MUL_A_W-crs_pkg::DIR_W){direction_value_ff[crs_pkg::DIR_W-1]}},
                        direction_value_ff};
               state_in = crs_pkg::ST_SH_1;
            end else begin
               mul_a    = {{(crs_pkg::MUL_A_W-crs_pkg::GAIN_P_W){1'b0}}, gain_p_ff};
               state_in = crs_pkg::ST_PD_M1;
            end
         end
         crs_pkg::ST_PD_M1: begin
            acc_in   = mul_p[crs_pkg::ACC_W-1:0];
            mul_a    = {{(crs_pkg::MUL_A_W-crs_pkg::GAIN_D_W){1'b0}}, gain_d_ff};
            mul_b    = {{(crs_pkg::MUL_B_W-crs_pkg::G_W){g_ff[crs_pkg::G_W-1]}}, g_ff};
            state_in = crs_pkg::ST_PD_M2;
         end
         crs_pkg::ST_PD_M2: begin
            acc_in = acc_ff + mul_p[crs_pkg::ACC_W-1:0];
            if (regime_value_ff == crs_pkg::REGIME_STRAIGHT) begin
               state_in = crs_pkg::ST_PD_M3;
            end else begin
               state_in = crs_pkg::ST_PD_END;
            end
         end
         crs_pkg::ST_PD_M3: begin
            mul_a    = acc_ff[crs_pkg::MUL_A_W-1:0];
            mul_b    = crs_pkg::STRAIGHT_GAIN_B;
            state_in = crs_pkg::ST_PD_M4;
         end
         crs_pkg::ST_PD_M4: begin
            acc_in   = mul_p[crs_pkg::ACC_W-1:0];
            state_in = crs_pkg::ST_PD_END;
         end
         crs_pkg::ST_SH_1: begin
            // squared direction times the quadratic coefficient
            mul_a    = mul_p[crs_pkg::MUL_A_W-1:0];
            mul_b    = {{(crs_pkg::MUL_B_W-crs_pkg::COEF_W){1'b0}}, quad_coef_ff};
            state_in = crs_pkg::ST_SH_2;
         end
         crs_pkg::ST_SH_2: begin
            // quadratic term and bias both follow the sign of the direction
            if (!direction_value_ff[crs_pkg::DIR_W-1]) begin
               acc_in = mul_p[crs_pkg::ACC_W-1:0] + crs_pkg::SHARP_BIAS_ACC;
            end else begin
               acc_in = -mul_p[crs_pkg::ACC_W-1:0] - crs_pkg::SHARP_BIAS_ACC;
            end
            mul_a = {{(crs_pkg::MUL_A_W-crs_pkg::COEF_W){lin_coef_ff[crs_pkg::COEF_W-1]}},
                     lin_coef_ff};
            mul_b = {{(crs_pkg::MUL_B_W-crs_pkg::DIR_W){direction_value_ff[crs_pkg::DIR_W-1]}},
                     direction_value_ff};
            state_in = crs_pkg::ST_SH_3;
         end
         crs_pkg::ST_SH_3: begin
            acc_in   = sharp_lin_sum;
            mul_a    = {{(crs_pkg::MUL_A_W-crs_pkg::GAIN_D_W){1'b0}}, gain_d_ff};
            mul_b    = {{(crs_pkg::MUL_B_W-crs_pkg::G_W){g_ff[crs_pkg::G_W-1]}}, g_ff};
            state_in = crs_pkg::ST_SH_4;
         end
         crs_pkg::ST_SH_4: begin
            acc_in   = sharp_lin_sum;
            state_in = crs_pkg::ST_PD_END;
         end
         crs_pkg::ST_PD_END: begin
            target_new_in = clamp_out(acc_sh);
            state_in      = crs_pkg::ST_FINISH;
         end
         crs_pkg::ST_OUT_MUL: begin
            mul_a    = {{(crs_pkg::MUL_A_W-crs_pkg::OUT_W-1){tdiff[crs_pkg::OUT_W]}}, tdiff};
            mul_b    = {{(crs_pkg::MUL_B_W-crs_pkg::PHASE_W){1'b0}}, phase_ff};
            state_in = crs_pkg::ST_OUT_DIVST;
         end
         crs_pkg::ST_OUT_DIVST: begin
            // divide the magnitude, truncation toward zero by sign afterwards
            neg_in        = mul_p[crs_pkg::MUL_P_W-1];
            div_req.start = 1'b1;
            div_req.top   = crs_pkg::INTERP_TOP;
            div_req.numer = {{(crs_pkg::NUM_W-crs_pkg::QUO_W){1'b0}},
                             prod_abs[crs_pkg::QUO_W-1:0]};
            div_req.denom = {{(crs_pkg::DEN_W-crs_pkg::PERIOD_W){1'b0}}, period_len_ff};
            state_in      = crs_pkg::ST_OUT_DIV;
         end
         crs_pkg::ST_OUT_DIV: begin
            if (div_rsp.done) begin
               drive_value_in = clamp_out(interp_sum);
               state_in       = crs_pkg::ST_FINISH;
            end
         end
         crs_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_drive_in     = drive_value_ff;
               rsp_target_in    = target_new_ff;
               rsp_direction_in = direction_value_ff;
               rsp_regime_in    = regime_value_ff;
               state_in         = crs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = crs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= crs_pkg::ST_IDLE;
         rsp_valid_ff       <= 1'b0;
         left_sum_ff        <= '0;
         right_sum_ff       <= '0;
         straight_count_ff  <= '0;
         target_old_ff      <= '0;
         target_new_ff      <= '0;
         drive_value_ff     <= '0;
         direction_value_ff <= '0;
         regime_value_ff    <= '0;
      end else begin
         state_ff           <= state_in;
         rsp_valid_ff       <= rsp_valid_in;
         left_sum_ff        <= left_sum_in;
         right_sum_ff       <= right_sum_in;
         straight_count_ff  <= straight_count_in;
         target_old_ff      <= target_old_in;
         target_new_ff      <= target_new_in;
         drive_value_ff     <= drive_value_in;
         direction_value_ff <= direction_value_in;
         regime_value_ff    <= regime_value_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff           <= acc_in;
      g_ff             <= g_in;
      tot_ff           <= tot_in;
      adiff_ff         <= adiff_in;
      neg_ff           <= neg_in;
      phase_ff         <= phase_in;
      rsp_drive_ff     <= rsp_drive_in;
      rsp_target_ff    <= rsp_target_in;
      rsp_direction_ff <= rsp_direction_in;
      rsp_regime_ff    <= rsp_regime_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.drive     = rsp_drive_ff;
   assign rsp_ch.target    = rsp_target_ff;
   assign rsp_ch.direction = rsp_direction_ff;
   assign rsp_ch.regime    = rsp_regime_ff;

endmodule

// ----- sim/crs_steer_checker.sv -----
// ----------------------------------------------------------------------------
// crs_steer_checker
// Watches the item, result and register ports of the coil ratio steering
// unit, predicts every result from its own copy of the steering state and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module crs_steer_checker (
   input  logic                               clock,
   input  logic                               reset,
   crs_req_if                                 req_ch,
   crs_rsp_if                                 rsp_ch,
   input  logic                               csr_wr_en,
   input  logic [crs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [crs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                 fail_count,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import crs_pkg::*;

   typedef struct {
      longint drive;
      longint target;
      longint direction;
      longint regime;
   } steer_result_type;

   // register copies
   longint cfg_enable, cfg_adc_offset, cfg_gyro_offset, cfg_gain_p;
   longint cfg_gain_d, cfg_quad, cfg_lin, cfg_period;

   // steering state
   longint left_acc, right_acc, straight_run;
   longint tgt_old, tgt_new, drive_now, dir_now, regime_now;

   steer_result_type expected_q[$];

   function automatic longint clamp_drive(input longint v);
      if (v > LIMIT) return LIMIT;
      if (v < -LIMIT) return -LIMIT;
      return v;
   endfunction

   function automatic longint sat_sum(input longint a, input longint b);
      longint top_val;
      top_val = (longint'(1) << SUM_BITS) - 1;
      return (a + b > top_val) ? top_val : a + b;
   endfunction

   task automatic advance_steering(input logic [OP_W-1:0] op,
                                   input longint lsamp, rsamp, gyro_v, ph);
      longint lv, rv, la, ra, tot, diff, mag, dir, absdir, gdel, acc, res, quad, bias;
      case (op)
         OP_SAMPLE: begin
            lv = (lsamp > cfg_adc_offset) ? lsamp - cfg_adc_offset : 0;
            rv = (rsamp > cfg_adc_offset) ? rsamp - cfg_adc_offset : 0;
            left_acc  = sat_sum(left_acc, lv);
            right_acc = sat_sum(right_acc, rv);
         end
         OP_CONTROL: begin
            if (cfg_enable == 0) begin
               // sums, run count, direction and regime are kept
               tgt_old   = 0;
               tgt_new   = 0;
               drive_now = 0;
            end else begin
               la = left_acc >> AVG_SHIFT;
               ra = right_acc >> AVG_SHIFT;
               left_acc  = 0;
               right_acc = 0;
               tot  = la + ra;
               diff = la - ra;
               if (tot == 0) begin
                  dir = 0;
               end else begin
                  mag = (diff < 0 ? -diff : diff) * DIR_SCALE / tot;
                  dir = (diff < 0) ? -mag : mag;
               end
               dir_now = dir;
               tgt_old = tgt_new;
               absdir  = (dir < 0) ? -dir : dir;
               if (absdir < STRAIGHT_BAND) begin
                  if (straight_run < 255) straight_run++;
               end else begin
                  straight_run = 0;
               end
               gdel = gyro_v - cfg_gyro_offset;
               acc  = dir * cfg_gain_p + gdel * cfg_gain_d;
               if (straight_run > STRAIGHT_RUN) begin
                  res = (acc * STRAIGHT_GAIN) >>> FRAC_SHIFT;
                  regime_now = REGIME_STRAIGHT;
               end else if (absdir < SHARP_BAND) begin
                  res = acc >>> NORMAL_SHIFT;
                  regime_now = REGIME_NORMAL;
               end else begin
                  // quadratic and bias terms take the sign of the direction
                  quad = cfg_quad * dir * dir;
                  bias = longint'(SHARP_BIAS) << FRAC_SHIFT;
                  if (dir <= 0) begin
                     quad = -quad;
                     bias = -bias;
                  end
                  acc = quad + ((cfg_lin * dir) <<< LIN_SHIFT) + bias
                        + ((gdel * cfg_gain_d) <<< LIN_SHIFT);
                  res = acc >>> FRAC_SHIFT;
                  regime_now = REGIME_SHARP;
               end
               tgt_new = clamp_drive(res);
            end
         end
         OP_OUTPUT: begin
            if (cfg_period == 0)
               drive_now = tgt_new;
            else
               drive_now = clamp_drive(tgt_old + (tgt_new - tgt_old) * ph / cfg_period);
         end
         default: ;
      endcase
      expected_q.push_back('{drive_now, tgt_new, dir_now, regime_now});
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      steer_result_type want;
      if (reset) begin
         cfg_enable      = 0;
         cfg_adc_offset  = 0;
         cfg_gyro_offset = 0;
         cfg_gain_p      = GAIN_P_RESET;
         cfg_gain_d      = 0;
         cfg_quad        = 0;
         cfg_lin         = 0;
         cfg_period      = PERIOD_RESET;
         left_acc        = 0;
         right_acc       = 0;
         straight_run    = 0;
         tgt_old         = 0;
         tgt_new         = 0;
         drive_now       = 0;
         dir_now         = 0;
         regime_now      = REGIME_STRAIGHT;
         expected_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               $display("%0t: result transfer with none expected, got drive %0d target %0d",
                        $time, rsp_ch.drive, rsp_ch.target);
            end else begin
               want = expected_q.pop_front();
               check_field("drive", want.drive, longint'(rsp_ch.drive));
               check_field("target", want.target, longint'(rsp_ch.target));
               check_field("direction", want.direction, longint'(rsp_ch.direction));
               check_field("regime", want.regime, longint'(rsp_ch.regime));
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ENABLE:      cfg_enable      = longint'(csr_wdata[0]);
               CSR_ADC_OFFSET:  cfg_adc_offset  = longint'(csr_wdata[SAMPLE_W-1:0]);
               CSR_GYRO_OFFSET: cfg_gyro_offset = longint'($signed(csr_wdata[GYRO_W-1:0]));
               CSR_GAIN_P:      cfg_gain_p      = longint'(csr_wdata[GAIN_P_W-1:0]);
               CSR_GAIN_D:      cfg_gain_d      = longint'(csr_wdata[GAIN_D_W-1:0]);
               CSR_QUAD_COEF:   cfg_quad        = longint'(csr_wdata[COEF_W-1:0]);
               CSR_LIN_COEF:    cfg_lin         = longint'($signed(csr_wdata[COEF_W-1:0]));
               CSR_PERIOD_LEN:  cfg_period      = longint'(csr_wdata[PERIOD_W-1:0]);
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            advance_steering(req_ch.operation, longint'(req_ch.left_sample),
                             longint'(req_ch.right_sample), longint'(req_ch.gyro),
                             longint'(req_ch.phase));
      end
      pending = expected_q.size();
   end

endmodule

// ----- sim/tb_coil_ratio_steering_pd_unit.sv -----
// ----------------------------------------------------------------------------
// tb_coil_ratio_steering_pd_unit
// Drives the coil ratio steering unit with directed items and with runs of
// coil samples, control updates and interpolation steps under several
// register settings and idle patterns; the checker beside it does the scoring.
// ----------------------------------------------------------------------------
module tb_coil_ratio_steering_pd_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import crs_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 12;
   localparam longint CYCLE_LIMIT = 1000000;
   localparam int PHASE_COUNT     = 8;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int SAT_RUN         = 530;
   localparam int HOLD_PHASE      = 4;
   localparam int LONG_HOLD       = 400;
   localparam int DRAIN_PHASE     = 5;
   localparam int DRAIN_EVERY     = 60;
   localparam int TAIL_CYCLES     = 40;
   localparam int SAMPLE_MAX      = 32767;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef enum int {MIX_BALANCED, MIX_MODERATE, MIX_SHARP, MIX_WILD} coil_mix_e;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int     fail_count;
   int     pending;
   int     req_idle_pct  = 0;
   int     rsp_stall_pct = 0;
   int     phase_id      = -1;
   int     items_sent    = 0;
   longint cycle_count   = 0;

   crs_req_if req_ch();
   crs_rsp_if rsp_ch();

   coil_ratio_steering_pd_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   crs_steer_checker steer_chk (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: random stalls plus one long hold-off
   initial begin : rsp_side
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (phase_id == HOLD_PHASE && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // entered and left at a falling edge; valid stays up for a back-to-back item
   task automatic send_item(input logic [OP_W-1:0] op, input int lsamp, rsamp, gyro_v, ph);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.operation    <= op;
      req_ch.left_sample  <= SAMPLE_W'(lsamp);
      req_ch.right_sample <= SAMPLE_W'(rsamp);
      req_ch.gyro         <= GYRO_W'(gyro_v);
      req_ch.phase        <= PHASE_W'(ph);
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // bits above the register width carry junk
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int width,
                            input longint data);
      logic [CSR_DATA_W-1:0] mask;
      mask = CSR_DATA_W'((longint'(1) << width) - 1);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (CSR_DATA_W'($urandom) & ~mask) | (CSR_DATA_W'(data) & mask);
      @(negedge clock);
   endtask

   task automatic program_phase(input int p);
      longint en, adc, goff, kp, kd, kq, klin, per;
      en   = 1;
      adc  = $urandom_range(0, 2000);
      goff = longint'($urandom_range(0, 4000)) - 2000;
      kp   = $urandom_range(0, 1024);
      kd   = $urandom_range(0, 2000);
      kq   = $urandom_range(0, 512);
      klin = longint'($urandom_range(0, 2048)) - 1024;
      per  = $urandom_range(1, 12);
      case (p)
         0: begin
            adc = 100; goff = 0; kp = 256; kd = 655; kq = 256; klin = 256; per = 5;
         end
         1: begin
            adc = 0; goff = -32768; kp = 65535; kd = 16777215;
            kq = 65535; klin = -32768; per = 255;
         end
         2: begin
            // every reading floors to zero, so the straight schedule takes over
            adc = SAMPLE_MAX; goff = 32767; kp = 0; kd = 0; kq = 0; klin = 32767; per = 1;
         end
         3: en = 0;
         4: per = 0;
         default: ;
      endcase
      wait_drained();
      phase_id = p;
      case (p % 4)
         0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin req_idle_pct = 58; rsp_stall_pct = 0;  end
         2: begin req_idle_pct = 0;  rsp_stall_pct = 58; end
         default: begin req_idle_pct = 17; rsp_stall_pct = 17; end
      endcase
      write_csr(CSR_ENABLE, 1, en);
      write_csr(CSR_ADC_OFFSET, SAMPLE_W, adc);
      write_csr(CSR_GYRO_OFFSET, GYRO_W, goff);
      write_csr(CSR_GAIN_P, GAIN_P_W, kp);
      write_csr(CSR_GAIN_D, GAIN_D_W, kd);
      write_csr(CSR_QUAD_COEF, COEF_W, kq);
      write_csr(CSR_LIN_COEF, COEF_W, klin);
      write_csr(CSR_PERIOD_LEN, PERIOD_W, per);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input int p);
      int        start_count, next_drain, run_left, nsamp, nout, ph, base, other;
      bit        swap;
      coil_mix_e mix;
      start_count = items_sent;
      next_drain  = items_sent + DRAIN_EVERY;
      run_left    = 0;
      swap        = 1'b0;
      mix         = MIX_WILD;
      if (p == 0) begin
         // enough full-scale readings to pin the left sum at its ceiling
         repeat (SAT_RUN)
            send_item(OP_SAMPLE, SAMPLE_MAX, $urandom_range(16384, SAMPLE_MAX),
                      $urandom, $urandom);
      end
      while (items_sent - start_count < ITEMS_PER_PHASE) begin
         if (p == DRAIN_PHASE && items_sent >= next_drain) begin
            wait_drained();
            next_drain = items_sent + DRAIN_EVERY;
         end
         if ($urandom_range(0, 99) < 8) begin
            send_item(OP_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
         end else begin
            // runs of sequences keep the same coil balance so that
            // straight stretches and sharp turns both build up
            if (run_left == 0) begin
               mix      = coil_mix_e'($urandom_range(0, 3));
               run_left = $urandom_range(1, 30);
            end
            run_left--;
            swap  = $urandom_range(0, 1);
            nsamp = $urandom_range(1, 6);
            repeat (nsamp) begin
               base = $urandom_range(0, SAMPLE_MAX);
               case (mix)
                  MIX_BALANCED: other = base + int'($urandom_range(0, base >> 6)) - (base >> 7);
                  MIX_MODERATE: other = base * int'($urandom_range(55, 100)) / 100;
                  MIX_SHARP:    other = base * int'($urandom_range(0, 30)) / 100;
                  default:      other = $urandom_range(0, SAMPLE_MAX);
               endcase
               if (other > SAMPLE_MAX) other = SAMPLE_MAX;
               if (swap)
                  send_item(OP_SAMPLE, other, base, $urandom, $urandom);
               else
                  send_item(OP_SAMPLE, base, other, $urandom, $urandom);
            end
            if ($urandom_range(0, 9) != 0)
               send_item(OP_CONTROL, $urandom, $urandom,
                         ($urandom_range(0, 1) != 0) ? int'($urandom)
                                                     : int'($urandom_range(0, 600)) - 300,
                         $urandom);
            nout = $urandom_range(1, 6);
            ph   = 0;
            repeat (nout) begin
               if ($urandom_range(0, 4) == 0) ph = $urandom_range(0, 255);
               send_item(OP_OUTPUT, $urandom, $urandom, $urandom, ph);
               ph++;
            end
         end
      end
   endtask

   initial begin : stimulus
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.operation    = OP_SAMPLE;
      req_ch.left_sample  = '0;
      req_ch.right_sample = '0;
      req_ch.gyro         = '0;
      req_ch.phase        = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // reset settings: control is off, so the sums must survive the update
      send_item(OP_SAMPLE, SAMPLE_MAX, 0, 0, 0);
      send_item(OP_CONTROL, 0, 0, 32767, 0);
      send_item(OP_OUTPUT, 0, 0, 0, 255);
      send_item(OP_UNUSED, SAMPLE_MAX, SAMPLE_MAX, -32768, 255);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         program_phase(p);
         if (p == 0) begin
            send_item(OP_CONTROL, 0, 0, 0, 0);
            // nothing accumulated since: zero sum
            send_item(OP_CONTROL, 0, 0, -32768, 0);
            send_item(OP_SAMPLE, 0, SAMPLE_MAX, 0, 0);
            send_item(OP_CONTROL, 0, 0, 32767, 0);
            send_item(OP_OUTPUT, 0, 0, 0, 0);
            send_item(OP_OUTPUT, 0, 0, 0, 2);
            send_item(OP_OUTPUT, 0, 0, 0, 5);
            // past the end of the period: extrapolate then saturate
            send_item(OP_OUTPUT, 0, 0, 0, 200);
            send_item(OP_SAMPLE, 12000, 9000, 0, 0);
            send_item(OP_SAMPLE, 0, 0, 0, 0);
            send_item(OP_CONTROL, 0, 0, 0, 0);
            // readings under the baseline floor to zero
            send_item(OP_SAMPLE, 50, 60, 0, 0);
            send_item(OP_CONTROL, 0, 0, 100, 0);
            send_item(OP_OUTPUT, 0, 0, 0, 3);
            send_item(OP_UNUSED, 0, 0, 0, 0);
         end
         run_phase(p);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
